// File: hw/rtl/rmp_pkg.sv
// Shared types, codes and constants of the Modbus register PDU master.
// Depends on nothing; every other file of the block imports it.
package rmp_pkg;

  // Default and fixed sizes.
  localparam int MaxRegistersDefault = 123;
  localparam int CntW                = 7;
  localparam int RunMax              = 6;
  localparam int RunIdxW             = 3;

  // Input item kinds.
  localparam logic [1:0] KIND_CMD  = 2'd0;
  localparam logic [1:0] KIND_WORD = 2'd1;
  localparam logic [1:0] KIND_RESP = 2'd2;

  // Function selector codes of a command.
  localparam logic [1:0] FSEL_RD_HOLD  = 2'd0;
  localparam logic [1:0] FSEL_RD_INPUT = 2'd1;
  localparam logic [1:0] FSEL_WR_HOLD  = 2'd2;
  localparam logic [1:0] FSEL_UNUSED   = 2'd3;

  // Modbus function codes on the wire.
  localparam logic [7:0] FC_RD_HOLD  = 8'h03;
  localparam logic [7:0] FC_RD_INPUT = 8'h04;
  localparam logic [7:0] FC_WR_HOLD  = 8'h10;
  localparam logic [7:0] EXC_FLAG    = 8'h80;

  // Result kinds.
  localparam logic [1:0] RES_REQ    = 2'd0;
  localparam logic [1:0] RES_WORD   = 2'd1;
  localparam logic [1:0] RES_STATUS = 2'd2;

  // Status codes.
  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_TOO_MANY  = 3'd1;
  localparam logic [2:0] ST_ADDR_WRAP = 3'd2;
  localparam logic [2:0] ST_EXCEPTION = 3'd3;
  localparam logic [2:0] ST_BAD_LEN   = 3'd4;

  // Transaction in progress.
  typedef enum logic [1:0] {
    PEND_IDLE     = 2'd0,
    PEND_RD_HOLD  = 2'd1,
    PEND_RD_INPUT = 2'd2,
    PEND_WR_HOLD  = 2'd3
  } pend_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [1:0]  function_select;
    logic [15:0] start_address;
    logic [15:0] register_count;
    logic [15:0] write_word;
    logic [7:0]  response_byte;
    logic        response_end;
  } rmp_in_t;

  typedef struct packed {
    logic [1:0]  result_kind;
    logic [7:0]  request_byte;
    logic        request_end;
    logic [15:0] register_word;
    logic [2:0]  status_code;
    logic [7:0]  exception_code;
    logic        run_last;
  } rmp_out_t;

  // All results caused by one input item.
  typedef struct packed {
    logic [RunIdxW-1:0]          count;
    rmp_out_t [RunMax-1:0]       res;
  } rmp_run_t;

  // Request byte result.
  function automatic rmp_out_t mk_req(input logic [7:0] b, input logic last);
    rmp_out_t r;
    r              = '0;
    r.result_kind  = RES_REQ;
    r.request_byte = b;
    r.request_end  = last;
    return r;
  endfunction

  // Read register word result.
  function automatic rmp_out_t mk_word(input logic [15:0] w);
    rmp_out_t r;
    r               = '0;
    r.result_kind   = RES_WORD;
    r.register_word = w;
    return r;
  endfunction

  // Final status result.
  function automatic rmp_out_t mk_status(input logic [2:0] st, input logic [7:0] exc);
    rmp_out_t r;
    r                = '0;
    r.result_kind    = RES_STATUS;
    r.status_code    = st;
    r.exception_code = exc;
    return r;
  endfunction

endpackage

// File: hw/rtl/rmp_engine.sv
// Transaction state and per-item decode of the Modbus register PDU master.
// Depends on rmp_pkg; builds the run of results for one accepted item.
module rmp_engine
  import rmp_pkg::*;
#(
  parameter int MAX_REGISTERS = MaxRegistersDefault
) (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_fire,
  input  rmp_in_t  in_data,
  output rmp_run_t run
);

  pend_t             pend_r, pend_nxt;
  logic [CntW-1:0]   cnt_r, cnt_nxt;
  logic [CntW-1:0]   left_r, left_nxt;
  logic [7:0]        idx_r, idx_nxt;
  logic [7:0]        hold_r, hold_nxt;
  logic              exc_r, exc_nxt;
  logic              len_r, len_nxt;

  logic              too_many;
  logic [16:0]       addr_end;
  logic              wr_cmd;
  logic [7:0]        fcode;
  pend_t             fpend;
  logic [7:0]        need;
  logic [8:0]        need_p1;
  logic [8:0]        need_p2;
  logic              rd;
  logic              word_emit;
  logic [2:0]        st;
  logic [RunIdxW-1:0] st_slot;

  // Command checks and header fields.
  assign too_many = in_data.register_count > 16'(MAX_REGISTERS);
  assign addr_end = {1'b0, in_data.start_address} + {1'b0, in_data.register_count};
  assign wr_cmd   = in_data.function_select == FSEL_WR_HOLD;

  always_comb begin
    unique case (in_data.function_select)
      FSEL_RD_HOLD: begin
        fcode = FC_RD_HOLD;
        fpend = PEND_RD_HOLD;
      end
      FSEL_RD_INPUT: begin
        fcode = FC_RD_INPUT;
        fpend = PEND_RD_INPUT;
      end
      default: begin
        fcode = FC_WR_HOLD;
        fpend = PEND_WR_HOLD;
      end
    endcase
  end

  // Expected response geometry of a read.
  assign need    = {cnt_r, 1'b0};
  assign need_p1 = {1'b0, need} + 9'd1;
  assign need_p2 = {1'b0, need} + 9'd2;
  assign rd      = pend_r != PEND_WR_HOLD;

  // Next state and the results of this item.
  always_comb begin
    pend_nxt  = pend_r;
    cnt_nxt   = cnt_r;
    left_nxt  = left_r;
    idx_nxt   = idx_r;
    hold_nxt  = hold_r;
    exc_nxt   = exc_r;
    len_nxt   = len_r;
    word_emit = 1'b0;
    st        = ST_OK;
    st_slot   = '0;
    run       = '0;
    unique case (in_data.kind)
      KIND_CMD: begin
        if (in_data.function_select != FSEL_UNUSED) begin
          if (too_many) begin
            pend_nxt   = PEND_IDLE;
            run.count  = RunIdxW'(1);
            run.res[0] = mk_status(ST_TOO_MANY, 8'h00);
          end else if (addr_end[16]) begin
            pend_nxt   = PEND_IDLE;
            run.count  = RunIdxW'(1);
            run.res[0] = mk_status(ST_ADDR_WRAP, 8'h00);
          end else begin
            pend_nxt   = fpend;
            cnt_nxt    = in_data.register_count[CntW-1:0];
            left_nxt   = wr_cmd ? in_data.register_count[CntW-1:0] : '0;
            idx_nxt    = '0;
            hold_nxt   = '0;
            exc_nxt    = 1'b0;
            len_nxt    = 1'b0;
            run.res[0] = mk_req(fcode, 1'b0);
            run.res[1] = mk_req(in_data.start_address[15:8], 1'b0);
            run.res[2] = mk_req(in_data.start_address[7:0], 1'b0);
            run.res[3] = mk_req(in_data.register_count[15:8], 1'b0);
            run.res[4] = mk_req(in_data.register_count[7:0], !wr_cmd);
            run.res[5] = mk_req({in_data.register_count[6:0], 1'b0},
                                in_data.register_count == 16'd0);
            run.count  = wr_cmd ? RunIdxW'(6) : RunIdxW'(5);
          end
        end
      end
      KIND_WORD: begin
        if (pend_r == PEND_WR_HOLD && left_r != '0) begin
          left_nxt   = left_r - CntW'(1);
          run.count  = RunIdxW'(2);
          run.res[0] = mk_req(in_data.write_word[15:8], 1'b0);
          run.res[1] = mk_req(in_data.write_word[7:0], left_r == CntW'(1));
        end
      end
      KIND_RESP: begin
        if (pend_r != PEND_IDLE) begin
          // Byte zero carries the function code or its exception flag.
          if (idx_r == 8'd0) begin
            if ((in_data.response_byte & EXC_FLAG) != 8'h00) begin
              exc_nxt = 1'b1;
            end
          end else if (idx_r == 8'd1) begin
            if (exc_r) begin
              hold_nxt = in_data.response_byte;
            end else if (rd && in_data.response_byte != need) begin
              len_nxt = 1'b1;
            end
          end else if (rd && !exc_r) begin
            if ({1'b0, idx_r} < need_p2) begin
              if (!idx_r[0]) begin
                hold_nxt = in_data.response_byte;
              end else begin
                word_emit = 1'b1;
              end
            end else begin
              len_nxt = 1'b1;
            end
          end
          if (idx_r != 8'hFF) begin
            idx_nxt = idx_r + 8'd1;
          end
          // Final status on the last response byte.
          if (exc_nxt) begin
            st = ST_EXCEPTION;
          end else if (rd && (len_nxt || {1'b0, idx_r} != need_p1)) begin
            st = ST_BAD_LEN;
          end else begin
            st = ST_OK;
          end
          st_slot = word_emit ? RunIdxW'(1) : RunIdxW'(0);
          if (word_emit) begin
            run.res[0] = mk_word({hold_r, in_data.response_byte});
          end
          if (in_data.response_end) begin
            run.res[st_slot] = mk_status(st, (st == ST_EXCEPTION) ? hold_nxt : 8'h00);
            pend_nxt         = PEND_IDLE;
            left_nxt         = '0;
          end
          run.count = RunIdxW'(word_emit) + RunIdxW'(in_data.response_end);
        end
      end
      default: begin
      end
    endcase
  end

  // Control state commits only on an accepted item.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r <= PEND_IDLE;
      cnt_r  <= '0;
      left_r <= '0;
      idx_r  <= '0;
      hold_r <= '0;
      exc_r  <= 1'b0;
      len_r  <= 1'b0;
    end else if (in_fire) begin
      pend_r <= pend_nxt;
      cnt_r  <= cnt_nxt;
      left_r <= left_nxt;
      idx_r  <= idx_nxt;
      hold_r <= hold_nxt;
      exc_r  <= exc_nxt;
      len_r  <= len_nxt;
    end
  end

endmodule

// File: hw/rtl/rmp_emitter.sv
// Result register of the Modbus register PDU master: holds one run of
// results and hands them out one per cycle while out_ready is high. Depends on rmp_pkg.
module rmp_emitter
  import rmp_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     load,
  input  rmp_run_t run,
  output logic     take_ok,
  output logic     out_valid,
  input  logic     out_ready,
  output rmp_out_t out_data
);

  rmp_out_t [RunMax-1:0] res_r;
  logic [RunIdxW-1:0]    idx_r, idx_nxt;
  logic [RunIdxW-1:0]    last_r, last_nxt;
  logic                  busy_r, busy_nxt;
  logic                  at_last;
  logic                  out_fire;

  assign at_last  = idx_r == last_r;
  assign out_fire = busy_r && out_ready;
  // A new run may load when idle or once the current one has its final result leaving.
  assign take_ok  = !busy_r || (out_ready && at_last);

  assign out_valid = busy_r;
  always_comb begin
    out_data          = res_r[idx_r];
    out_data.run_last = at_last;
  end

  // Run sequencing.
  always_comb begin
    idx_nxt  = idx_r;
    last_nxt = last_r;
    busy_nxt = busy_r;
    if (out_fire) begin
      if (at_last) begin
        busy_nxt = 1'b0;
      end else begin
        idx_nxt = idx_r + RunIdxW'(1);
      end
    end
    if (load) begin
      busy_nxt = 1'b1;
      idx_nxt  = '0;
      last_nxt = run.count - RunIdxW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      idx_r  <= '0;
      last_r <= '0;
    end else begin
      busy_r <= busy_nxt;
      idx_r  <= idx_nxt;
      last_r <= last_nxt;
    end
  end

  // Result payload.
  always_ff @(posedge clk) begin
    if (load) begin
      res_r <= run.res;
    end
  end

endmodule

// File: hw/rtl/modbus_register_pdu_master.sv
// Top level of the Modbus register PDU master (functions 0x03, 0x04, 0x10).
// Depends on rmp_pkg, rmp_engine and rmp_emitter.
//
// Commands, write words and response bytes enter on the in_ channel, one
// request per cycle when the output keeps up. Each item is decoded in the
// cycle it is accepted and its results (none to six) land in a result
// register; they leave on the out_ channel one per cycle while out_ready is
// high, from the next cycle on, the last one flagged by run_last. The next
// item is taken in the same cycle as the final result of the previous one
// leaves. Response bytes therefore sustain one item per cycle, except a
// final byte that also completes a read word, which yields two results. A
// write word yields two results, a rejected command one, and a command
// header five or six.
module modbus_register_pdu_master
  import rmp_pkg::*;
#(
  parameter int MAX_REGISTERS = MaxRegistersDefault
) (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  input  rmp_in_t  in_data,
  output logic     out_valid,
  input  logic     out_ready,
  output rmp_out_t out_data
);

  rmp_run_t run;
  logic     in_fire;
  logic     take_ok;

  assign in_ready = take_ok;
  assign in_fire  = in_valid && in_ready;

  rmp_engine #(
    .MAX_REGISTERS(MAX_REGISTERS)
  ) u_engine (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_fire (in_fire),
    .in_data (in_data),
    .run     (run)
  );

  rmp_emitter u_emitter (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (in_fire && (run.count != '0)),
    .run       (run),
    .take_ok   (take_ok),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  // A new request is taken while results wait only as the last one leaves.
  a_ready_only_at_run_end: assert property (@(posedge clk) disable iff (!rst_n)
    in_ready && out_valid |-> out_ready && out_data.run_last)
    else $error("input taken while a run still has results pending");

  // A status always closes its run.
  a_status_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.result_kind == RES_STATUS |-> out_data.run_last)
    else $error("status result not last in its run");

  // The end-of-request flag appears only on request bytes.
  a_req_end_kind: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.request_end |-> out_data.result_kind == RES_REQ)
    else $error("request_end set on a non-request result");

endmodule
